// ----- hdl/brpl_pkg.sv -----
// ----------------------------------------------------------------------------
// brpl_pkg
// Shared types and constants for the block rms / peak level meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brpl_pkg;

  // level outputs are thousandths of full scale
  localparam int LVL_W = 10;

  // full-width operands for the shared multiplier
  localparam int MUL_W = 32;

  localparam logic [MUL_W-1:0] FULL_SCALE = 32'd32767;
  localparam logic [MUL_W-1:0] MILLI      = 32'd1000;
  localparam logic [MUL_W-1:0] MILLION    = 32'd1000000;

  // rms cap as a level value
  localparam logic [LVL_W-1:0] LVL_CAP = 10'd1000;

  // configuration register indexes
  localparam logic REG_HOLD_MS    = 1'b0;
  localparam logic REG_DECAY_STEP = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQUARE,
    S_ACC,
    S_RHS_LO,
    S_RHS_HI,
    S_RHS_ADD,
    S_PEAK,
    S_TRY,
    S_PSQ,
    S_CNT_LO,
    S_CNT_HI,
    S_CMP,
    S_HOLD
  } state_t;

endpackage

// ----- hdl/block_rms_peak_level_meter_core.sv -----
// ----------------------------------------------------------------------------
// block_rms_peak_level_meter_core
// Block rms and peak level meter with peak hold, one shared multiplier.
//
// Samples are taken one word at a time. Each word passes through the accept,
// square and accumulate steps, so in_ready comes back only once the square
// and accumulate steps are done. The word that closes a block (last_in_block
// set, or the MAX_BLOCK-th word) adds the end-of-block work: S_RHS_LO,
// S_RHS_HI and S_RHS_ADD form 10^6 * sum and the peak product, S_PEAK forms
// the peak level, then a ten-step binary search for the rms level runs each
// trial through S_TRY, S_PSQ, S_CNT_LO, S_CNT_HI and S_CMP (a trial above
// the cap is skipped in S_TRY alone; skips only happen close to the cap, at
// most four of them), and a final S_HOLD step updates the hold level and
// loads the result register. Every product goes through a single 32x32
// multiplier whose output is registered. The result word waits in its own
// register, so the next sample is taken while it waits; only a second
// closing block stalls until the first result has gone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_rms_peak_level_meter_core #(
  parameter int MAX_BLOCK = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            sample,
  input  logic                          last_in_block,
  input  logic [31:0]                   now_ms,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [brpl_pkg::LVL_W-1:0]    rms_level,
  output logic [brpl_pkg::LVL_W-1:0]    peak_level,
  output logic [brpl_pkg::LVL_W-1:0]    held_peak,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import brpl_pkg::*;

  // count must hold MAX_BLOCK itself at block close
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);

  // configuration registers
  logic [15:0]      hold_ms;
  logic [9:0]       decay_step;

  // sequencer
  state_t           state;
  state_t           state_next;

  // captured sample word
  logic [15:0]      mag;
  logic             last_flag;
  logic [31:0]      now_stamp;

  // block accumulation state
  logic [39:0]      square_sum;
  logic [CNT_W-1:0] sample_count;
  logic [14:0]      block_peak;
  logic [LVL_W-1:0] hold_level;
  logic [31:0]      hold_stamp;

  // shared multiplier and its registered product
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [2*MUL_W-1:0] prod;

  // search registers
  logic [59:0]      rhs;
  logic [49:0]      psq;
  logic [35:0]      lhs_lo;
  logic [LVL_W-1:0] rms_m;
  logic [LVL_W-1:0] trial_bit;
  logic [LVL_W-1:0] peak_q;

  // combinational helpers
  logic [40:0]      sum_ext;
  logic [14:0]      mag_sat;
  logic [CNT_W-1:0] count_inc;
  logic             block_close;
  logic [LVL_W-1:0] trial;
  logic             trial_skip;
  logic [60:0]      lhs_full;
  logic [LVL_W-1:0] pk_q;
  logic [15:0]      pk_r;
  logic [LVL_W-1:0] pk_level;
  logic             hold_go;
  logic [31:0]      elapsed;
  logic             cfg_wr;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms    <= 16'd1000;
      decay_step <= 10'd12;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_HOLD_MS:    hold_ms    <= pwdata[15:0];
        REG_DECAY_STEP: decay_step <= pwdata[9:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HOLD_MS:    prdata = {16'd0, hold_ms};
      REG_DECAY_STEP: prdata = {22'd0, decay_step};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath helpers
  // --------------------------------------------------------------------------
  // accumulate with saturation at the top of the 40-bit range
  assign sum_ext     = {1'b0, square_sum} + {1'b0, prod[39:0]};
  // most negative sample reads as full scale for the peak
  assign mag_sat     = (mag > 16'h7fff) ? 15'h7fff : mag[14:0];
  assign count_inc   = sample_count + CNT_W'(1);
  assign block_close = last_flag || (count_inc >= CNT_W'(MAX_BLOCK));

  assign trial       = rms_m | trial_bit;
  assign trial_skip  = (trial > LVL_CAP);
  // (trial*32767)^2 * count, upper partial product arriving now
  assign lhs_full    = {25'd0, lhs_lo} + {prod[35:0], 25'd0};

  // peak * 1000 / 32767: quotient by 2^15, then one correction step
  assign pk_q        = prod[24:15];
  assign pk_r        = {1'b0, prod[14:0]} + {6'd0, pk_q};
  assign pk_level    = (pk_r >= FULL_SCALE[15:0]) ? pk_q + LVL_W'(1) : pk_q;

  assign elapsed     = now_stamp - hold_stamp;
  // result register free, or being emptied this cycle
  assign hold_go     = (state == S_HOLD) && (!out_valid || out_ready);

  // --------------------------------------------------------------------------
  // shared multiplier
  // --------------------------------------------------------------------------
  assign mul_p = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

  always_ff @(posedge clk) begin
    prod <= mul_p;
  end

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_SQUARE;
      S_SQUARE:  state_next = S_ACC;
      S_ACC:     state_next = block_close ? S_RHS_LO : S_IDLE;
      S_RHS_LO:  state_next = S_RHS_HI;
      S_RHS_HI:  state_next = S_RHS_ADD;
      S_RHS_ADD: state_next = S_PEAK;
      S_PEAK:    state_next = S_TRY;
      S_TRY: begin
        if (!trial_skip) begin
          state_next = S_PSQ;
        end else if (trial_bit[0]) begin
          state_next = S_HOLD;
        end
      end
      S_PSQ:     state_next = S_CNT_LO;
      S_CNT_LO:  state_next = S_CNT_HI;
      S_CNT_HI:  state_next = S_CMP;
      S_CMP:     state_next = trial_bit[0] ? S_HOLD : S_TRY;
      S_HOLD:    if (hold_go) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: outputs (handshake and multiplier operands)
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      S_IDLE:    in_ready = 1'b1;
      S_SQUARE: begin
        mul_a = MUL_W'(mag);
        mul_b = MUL_W'(mag);
      end
      S_RHS_LO: begin
        mul_a = MUL_W'(square_sum[19:0]);
        mul_b = MILLION;
      end
      S_RHS_HI: begin
        mul_a = MUL_W'(square_sum[39:20]);
        mul_b = MILLION;
      end
      S_RHS_ADD: begin
        mul_a = MUL_W'(block_peak);
        mul_b = MILLI;
      end
      S_TRY: begin
        mul_a = MUL_W'(trial);
        mul_b = FULL_SCALE;
      end
      S_PSQ: begin
        mul_a = MUL_W'(prod[24:0]);
        mul_b = MUL_W'(prod[24:0]);
      end
      S_CNT_LO: begin
        mul_a = MUL_W'(prod[24:0]);
        mul_b = MUL_W'(sample_count);
      end
      S_CNT_HI: begin
        mul_a = MUL_W'(psq[49:25]);
        mul_b = MUL_W'(sample_count);
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // sample capture and block accumulation
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mag       <= sample[15] ? 16'(-sample) : sample;
      last_flag <= last_in_block;
      now_stamp <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      sample_count <= '0;
      block_peak   <= '0;
    end else if (state == S_ACC) begin
      square_sum   <= sum_ext[40] ? 40'hff_ffff_ffff : sum_ext[39:0];
      sample_count <= count_inc;
      if (mag_sat > block_peak) begin
        block_peak <= mag_sat;
      end
    end else if (hold_go) begin
      square_sum   <= '0;
      sample_count <= '0;
      block_peak   <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // rms search: largest m up to the cap with (m*32767)^2 * count <= 10^6 * sum
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      S_RHS_HI:  rhs    <= {20'd0, prod[39:0]};
      S_RHS_ADD: rhs    <= rhs + {prod[39:0], 20'd0};
      S_CNT_LO:  psq    <= prod[49:0];
      S_CNT_HI:  lhs_lo <= prod[35:0];
      S_PEAK:    peak_q <= pk_level;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trial_bit <= {1'b1, {(LVL_W-1){1'b0}}};
      rms_m     <= '0;
    end else begin
      case (state)
        S_PEAK: begin
          trial_bit <= {1'b1, {(LVL_W-1){1'b0}}};
          rms_m     <= '0;
        end
        S_TRY: begin
          // over the cap: drop this bit without a trial
          if (trial_skip && !trial_bit[0]) begin
            trial_bit <= trial_bit >> 1;
          end
        end
        S_CMP: begin
          if (lhs_full <= {1'b0, rhs}) begin
            rms_m <= trial;
          end
          if (!trial_bit[0]) begin
            trial_bit <= trial_bit >> 1;
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // peak hold and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_level <= '0;
      hold_stamp <= '0;
    end else if (hold_go) begin
      if (peak_q >= hold_level) begin
        // rise or equal: follow at once and restart the hold time
        hold_level <= peak_q;
        hold_stamp <= now_stamp;
      end else if (elapsed > {16'd0, hold_ms}) begin
        hold_level <= (hold_level > decay_step) ? hold_level - decay_step : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_go) begin
      rms_level  <= rms_m;
      peak_level <= peak_q;
      if (peak_q >= hold_level) begin
        held_peak <= peak_q;
      end else if (elapsed > {16'd0, hold_ms}) begin
        held_peak <= (hold_level > decay_step) ? hold_level - decay_step : '0;
      end else begin
        held_peak <= hold_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hold_go) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_accept_starts_square: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SQUARE)
  ) else $error("accepted word did not start the square step");

  a_trial_bit_onehot: assert property (
    @(posedge clk) disable iff (rst)
    $onehot(trial_bit)
  ) else $error("search bit lost its one-hot form");

  a_count_in_range: assert property (
    @(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(MAX_BLOCK)
  ) else $error("sample count beyond block length");

  a_levels_capped: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> (rms_level <= LVL_CAP && peak_level <= LVL_CAP && held_peak <= LVL_CAP)
  ) else $error("level output above full scale");

endmodule

// ----- test/brpl_level_checker.sv -----
// ----------------------------------------------------------------------------
// brpl_level_checker
// Watches the sample, result and configuration channels of the level meter,
// keeps its own copy of the meter state and checks every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brpl_level_checker #(
  parameter int MAX_BLOCK = 512
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [15:0]         sample,
  input  logic                       last_in_block,
  input  logic [31:0]                now_ms,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [brpl_pkg::LVL_W-1:0] rms_level,
  input  logic [brpl_pkg::LVL_W-1:0] peak_level,
  input  logic [brpl_pkg::LVL_W-1:0] held_peak,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         mismatches,
  output int                         pending
);
  import brpl_pkg::*;

  localparam logic [31:0] FS         = 32'd32767;
  localparam logic [31:0] PER_MILLE  = 32'd1000;
  localparam logic [39:0] SUM_TOP    = '1;
  localparam int          REPORT_MAX = 10;

  localparam logic [2:0] ADDR_HOLD_MS = {REG_HOLD_MS, 2'b00};
  localparam logic [2:0] ADDR_DECAY   = {REG_DECAY_STEP, 2'b00};

  typedef struct packed {
    logic [LVL_W-1:0] rms;
    logic [LVL_W-1:0] peak;
    logic [LVL_W-1:0] held;
  } levels_t;

  levels_t          levels_due[$];
  logic [15:0]      hold_ms_cfg;
  logic [9:0]       decay_cfg;
  logic [39:0]      sq_sum;
  logic [10:0]      taken;
  logic [14:0]      blk_peak;
  logic [LVL_W-1:0] held;
  logic [31:0]      held_at;
  int               n_bad = 0;

  // largest m up to the cap with (m*fs)^2 * n <= 10^6 * sum
  function automatic logic [LVL_W-1:0] rms_thousandths(input logic [39:0] sum,
                                                       input logic [10:0] n);
    logic [79:0]      lim;
    logic [79:0]      lhs;
    logic [LVL_W-1:0] m;
    logic [LVL_W-1:0] trial;
    int               b;
    lim = 80'(sum) * 80'd1000000;
    m = '0;
    for (b = LVL_W - 1; b >= 0; b--) begin
      trial = m | LVL_W'(1 << b);
      if (32'(trial) <= PER_MILLE) begin
        lhs = 80'(trial) * 80'(FS);
        lhs = lhs * lhs * 80'(n);
        if (lhs <= lim) m = trial;
      end
    end
    return m;
  endfunction

  task automatic take_word(input logic signed [15:0] s, input logic l,
                           input logic [31:0] t);
    int          v;
    int          mag;
    logic [40:0] wide;
    logic [10:0] n;
    logic [31:0] pk;
    levels_t     r;
    v = int'(s);
    mag = (v < 0) ? -v : v;
    wide = 41'(sq_sum) + 41'(longint'(mag) * longint'(mag));
    sq_sum = (wide > 41'(SUM_TOP)) ? SUM_TOP : wide[39:0];
    if (mag > 32767) mag = 32767;
    if (mag > int'(blk_peak)) blk_peak = mag[14:0];
    n = taken + 11'd1;
    if (!l && n < MAX_BLOCK) begin
      taken = n;
    end else begin
      pk = 32'(blk_peak) * PER_MILLE / FS;
      if (pk >= 32'(held)) begin
        held = pk[LVL_W-1:0];
        held_at = t;
      end else if ((t - held_at) > 32'(hold_ms_cfg)) begin
        held = (held > decay_cfg) ? held - decay_cfg : '0;
      end
      r.rms = rms_thousandths(sq_sum, n);
      r.peak = pk[LVL_W-1:0];
      r.held = held;
      levels_due.push_back(r);
      sq_sum = '0;
      taken = '0;
      blk_peak = '0;
    end
  endtask

  always @(posedge clk) begin
    levels_t want;
    if (rst) begin
      hold_ms_cfg = 16'd1000;
      decay_cfg = 10'd12;
      sq_sum = '0;
      taken = '0;
      blk_peak = '0;
      held = '0;
      held_at = '0;
      levels_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_HOLD_MS: hold_ms_cfg = pwdata[15:0];
          ADDR_DECAY:   decay_cfg = pwdata[9:0];
          default: ;
        endcase
      end
      // result side first: a word closing a block now cannot be answered yet
      if (out_valid && out_ready) begin
        if (levels_due.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_MAX)
            $display("%0t: unexpected result word rms %0d peak %0d held %0d",
                     $time, rms_level, peak_level, held_peak);
        end else begin
          want = levels_due.pop_front();
          if (want.rms != rms_level || want.peak != peak_level ||
              want.held != held_peak) begin
            n_bad++;
            if (n_bad <= REPORT_MAX)
              $display("%0t: level mismatch rms exp %0d got %0d, peak exp %0d got %0d, held exp %0d got %0d",
                       $time, want.rms, rms_level, want.peak, peak_level,
                       want.held, held_peak);
          end
        end
      end
      if (in_valid && in_ready) take_word(sample, last_in_block, now_ms);
    end
    mismatches <= n_bad;
    pending <= levels_due.size();
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives samples and register writes into the block rms / peak level meter,
// with random gaps on both channels, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import brpl_pkg::*;

  localparam int MAX_BLOCK = 512;
  // no word may be stuck longer than this; the slowest honest gap is the long
  // hold-off plus a closing word plus the settle pause
  localparam int LIMIT     = 5000;
  // pause that lets a closing word pass all the way through the block
  localparam int SETTLE    = 80;
  localparam int HOLD_OFF  = 400;
  localparam int IDLE_PCT  = 31;

  localparam logic [2:0] ADDR_HOLD_MS = {REG_HOLD_MS, 2'b00};
  localparam logic [2:0] ADDR_DECAY   = {REG_DECAY_STEP, 2'b00};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  wire                in_ready;
  logic signed [15:0] sample = '0;
  logic               last_in_block = 1'b0;
  logic [31:0]        now_ms = '0;
  wire                out_valid;
  logic               out_ready = 1'b0;
  wire [LVL_W-1:0]    rms_level;
  wire [LVL_W-1:0]    peak_level;
  wire [LVL_W-1:0]    held_peak;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  wire [31:0]         prdata;
  wire                pready;

  int mismatches;
  int pending;

  int          cyc = 0;
  logic        calm;
  logic [31:0] wall_ms = '0;
  logic [15:0] hold_pick;
  logic [9:0]  decay_pick;

  // a window with no idling on either side
  assign calm = (cyc >= 3000 && cyc < 4500);

  always #5 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;

  block_rms_peak_level_meter_core #(.MAX_BLOCK(MAX_BLOCK)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample(sample), .last_in_block(last_in_block), .now_ms(now_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .rms_level(rms_level), .peak_level(peak_level), .held_peak(held_peak),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  brpl_level_checker #(.MAX_BLOCK(MAX_BLOCK)) level_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample(sample), .last_in_block(last_in_block), .now_ms(now_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .rms_level(rms_level), .peak_level(peak_level), .held_peak(held_peak),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .pending(pending)
  );

  // watchdog: cycles in a row in which no word moves on either channel
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side: random back-pressure, and once a long hold-off so that the
  // block fills up behind a waiting result and stalls the sample channel
  int results_taken = 0;
  int hold_off_left = 0;
  bit held_off = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready <= 1'b0;
    end else if (!held_off && results_taken == 8) begin
      held_off <= 1'b1;
      hold_off_left <= HOLD_OFF;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
    if (out_valid && out_ready) results_taken <= results_taken + 1;
  end

  // offer one sample word, with random gaps ahead of it, and hold it until taken
  task automatic send_word(input logic signed [15:0] s, input logic l,
                           input logic [31:0] t);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    last_in_block <= l;
    now_ms <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait for every result still owed, then let a non-closing word drain too
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // setup cycle then access cycle; upper data bits carry junk on purpose
  task automatic write_reg(input logic [2:0] a, input logic [31:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] hold, input logic [9:0] decay);
    settle();
    write_reg(ADDR_HOLD_MS, {16'($urandom), hold});
    write_reg(ADDR_DECAY, {22'($urandom), decay});
  endtask

  // whole blocks of random length and loudness; the closing word carries the
  // running time stamp, sometimes a wild jump, while inner words may carry junk
  task automatic random_blocks(input int budget, input int advance_max);
    int                 len;
    int                 shift;
    int                 k;
    int                 sent;
    logic signed [15:0] s;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      shift = ($urandom_range(9) == 0) ? 15 : $urandom_range(14);
      for (k = 0; k < len; k++) begin
        case ($urandom_range(19))
          0:       s = 16'sh8000;
          1:       s = 16'sh7fff;
          default: s = $signed(16'($urandom)) >>> shift;
        endcase
        if (k == len - 1) begin
          if ($urandom_range(19) == 0) wall_ms = $urandom;
          else wall_ms = wall_ms + $urandom_range(advance_max);
          send_word(s, 1'b1, wall_ms);
        end else begin
          send_word(s, 1'b0, ($urandom_range(15) == 0) ? $urandom : wall_ms);
        end
        sent++;
      end
    end
  endtask

  // one block that closes on its length alone
  task automatic full_block();
    int k;
    for (k = 0; k < MAX_BLOCK; k++)
      send_word($signed(16'($urandom)) >>> $urandom_range(15), 1'b0, wall_ms + k);
    wall_ms = wall_ms + MAX_BLOCK;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset values written back explicitly
    set_config(16'd1000, 10'd12);

    // silent block: hold rises from 0 to 0 and takes the stamp
    send_word(16'sd0, 1'b1, 32'd0);
    // full scale both ways; the most negative sample saturates the peak
    send_word(16'sh7fff, 1'b1, 32'd10);
    send_word(16'sh8000, 1'b1, 32'd20);
    // tiny two-word block, peak rounds down to 0
    send_word(-16'sd1, 1'b0, 32'd30);
    send_word(16'sd1, 1'b1, 32'd40);
    // elapsed exactly hold_ms: no decay; one more ms: decay
    send_word(16'sd100, 1'b1, 32'd1020);
    send_word(16'sd100, 1'b1, 32'd1021);
    // rise just short of the wrap, then the same boundary across the wrap
    send_word(16'sh7fff, 1'b1, 32'hffff_ff00);
    send_word(16'sd200, 1'b1, 32'd744);
    send_word(16'sd200, 1'b1, 32'd745);
    // alternating full scale, rms over full scale and capped
    send_word(16'sh7fff, 1'b0, 32'd800);
    send_word(16'sh8000, 1'b0, 32'd800);
    send_word(16'sh7fff, 1'b0, 32'd800);
    send_word(16'sh8000, 1'b1, 32'd800);
    // mid-level block for an rms away from the ends
    send_word(16'sd16384, 1'b0, 32'd900);
    send_word(-16'sd16384, 1'b0, 32'd900);
    send_word(16'sd8192, 1'b1, 32'd900);
    wall_ms = 32'd900;
    random_blocks(90, 600);

    // no hold at all, decay step at least as large as any level
    set_config(16'd0, 10'd1000);
    send_word(16'sh7fff, 1'b1, 32'd5000);
    send_word(16'sd0, 1'b1, 32'd5000);
    send_word(16'sd0, 1'b1, 32'd5001);
    wall_ms = 32'd5001;
    random_blocks(90, 3);

    // longest hold, no decay, and one block closing on its length
    set_config(16'hffff, 10'd0);
    random_blocks(45, 40000);
    full_block();
    random_blocks(45, 40000);

    hold_pick = 16'($urandom_range(3000));
    decay_pick = 10'($urandom_range(1000));
    set_config(hold_pick, decay_pick);
    random_blocks(90, 2 * int'(hold_pick) + 2);

    set_config(16'd1, 10'd1);
    random_blocks(90, 8);

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
